// File: rtl/lct_pkg.sv
// shared constants and widths for the load cell torque vectoring block
package lct_pkg;

  localparam int unsigned Corners     = 4;
  localparam int unsigned RawW        = 12;
  localparam int unsigned FracW       = 12;
  localparam int unsigned TorqueW     = 20;
  localparam int unsigned SpeedW      = 17;
  localparam int unsigned CountW      = 8;
  localparam int unsigned LoadW       = 30;
  localparam int unsigned SumW        = 32;
  localparam int unsigned QuotW       = 20;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned InDataW     = 80;
  localparam int unsigned OutDataW    = 104;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSpeedMode    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegErrorLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCellScales   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCellOffsets  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDriveSplit   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRegenSplit   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRegenLimits  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMotorRatings = 3'd7;

  // reset values
  localparam logic [7:0]  ErrorLimitRst  = 8'd10;
  localparam logic [63:0] CellScalesRst  = 64'h0100_0100_0100_0100;
  localparam logic [31:0] SplitRst       = 32'h4000_4000;

  // torque saturation bounds
  localparam logic [TorqueW-1:0] TorqueMaxPos = 20'h7FFFF;
  localparam logic [TorqueW-1:0] TorqueMinNeg = 20'h80000;
  localparam logic [CountW-1:0]  CountSat     = 8'hFF;

endpackage

// File: rtl/load_cell_torque_vectoring.sv
// load cell torque vectoring controller with a shared multiplier and divider step
// drive mode runs four corners of one multiply, one range check and a 20-step
// restoring division each, all on one shared multiplier and one subtractor
// throughput: one sample at a time, next sample taken once the result is registered
// reset: config registers take their documented defaults, invalid run counts clear
module load_cell_torque_vectoring (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lct_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lct_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // accel_fraction, brake_fraction, raw_fl, raw_fr, raw_rl, raw_rr,
  // valid_fl, valid_fr, valid_rl, valid_rr, zero fill
  input  logic [lct_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mode_out, torque_fl, torque_fr, torque_rl, torque_rr, wheel_speed, fault, zero fill
  output logic [lct_pkg::OutDataW-1:0]      m_axis_tdata
);

  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StSum,
    StDispatch,
    StSpeed,
    StRegenA,
    StRegenB,
    StDriveP,
    StDriveD,
    StDriveM,
    StDriveChk,
    StDriveDiv,
    StDriveWr,
    StDone
  } state_e;

  // configuration
  logic        speed_mode_q;
  logic [7:0]  error_limit_q;
  logic [63:0] cell_scales_q;
  logic [63:0] cell_offsets_q;
  logic [31:0] drive_split_q;
  logic [31:0] regen_split_q;
  logic [31:0] regen_limits_q;
  logic [47:0] motor_ratings_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_mode_q    <= 1'b0;
      error_limit_q   <= lct_pkg::ErrorLimitRst;
      cell_scales_q   <= lct_pkg::CellScalesRst;
      cell_offsets_q  <= '0;
      drive_split_q   <= lct_pkg::SplitRst;
      regen_split_q   <= lct_pkg::SplitRst;
      regen_limits_q  <= '0;
      motor_ratings_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lct_pkg::RegSpeedMode:    speed_mode_q    <= cfg_data_i[0];
        lct_pkg::RegErrorLimit:   error_limit_q   <= cfg_data_i[7:0];
        lct_pkg::RegCellScales:   cell_scales_q   <= cfg_data_i;
        lct_pkg::RegCellOffsets:  cell_offsets_q  <= cfg_data_i;
        lct_pkg::RegDriveSplit:   drive_split_q   <= cfg_data_i[31:0];
        lct_pkg::RegRegenSplit:   regen_split_q   <= cfg_data_i[31:0];
        lct_pkg::RegRegenLimits:  regen_limits_q  <= cfg_data_i[31:0];
        lct_pkg::RegMotorRatings: motor_ratings_q <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  state_e state_q;
  logic [1:0]  corner_q;
  logic [4:0]  step_q;
  logic [lct_pkg::CountW-1:0] runs_q [lct_pkg::Corners];
  logic [lct_pkg::RawW-1:0]   raw_q  [lct_pkg::Corners];
  logic [lct_pkg::LoadW-1:0]  load_q [lct_pkg::Corners];
  logic [lct_pkg::TorqueW-1:0] tq_q  [lct_pkg::Corners];
  logic [lct_pkg::SumW-1:0]   sum_q;
  logic        ok_q;
  logic        a_neg_q;
  logic [11:0] a_mag_q;
  logic [29:0] p_q;
  logic [27:0] t_q;
  logic [31:0] d_q [2];
  logic [48:0] num_q;
  logic        neg_q;
  logic [30:0] rem_q;
  logic [lct_pkg::QuotW-1:0] quo_q;
  logic [lct_pkg::SpeedW-1:0] speed_q;
  logic        fault_q;
  logic        out_valid_q;
  logic [lct_pkg::OutDataW-1:0] out_data_q;

  logic in_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // invalid run counts after this sample, and the fault test on them
  logic [lct_pkg::CountW-1:0] runs_d [lct_pkg::Corners];
  logic ok_d;
  always_comb begin
    ok_d = 1'b1;
    for (int i = 0; i < lct_pkg::Corners; i++) begin
      if (s_axis_tdata[72 + i]) begin
        runs_d[i] = '0;
      end else if (runs_q[i] == lct_pkg::CountSat) begin
        runs_d[i] = runs_q[i];
      end else begin
        runs_d[i] = runs_q[i] + 8'd1;
      end
      if (runs_d[i] >= error_limit_q) begin
        ok_d = 1'b0;
      end
    end
  end

  logic [12:0] a_diff;
  assign a_diff = {1'b0, s_axis_tdata[11:0]} - {1'b0, s_axis_tdata[23:12]};

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [29:0] load_abs;
  always_comb begin
    load_abs = load_q[corner_q][29] ? (30'd0 - load_q[corner_q]) : load_q[corner_q];
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StLoad: begin
        mul_a = {20'd0, raw_q[corner_q]};
        mul_b = {16'd0, cell_scales_q[{corner_q, 4'd0} +: 16]};
      end
      StSpeed: begin
        mul_a = {20'd0, a_mag_q};
        mul_b = {16'd0, motor_ratings_q[47:32]};
      end
      StRegenA: begin
        mul_a = {20'd0, a_mag_q};
        mul_b = {16'd0, motor_ratings_q[31:16]};
      end
      StRegenB: begin
        mul_a = {4'd0, t_q};
        mul_b = {16'd0, regen_split_q[{corner_q[0], 4'd0} +: 16]};
      end
      StDriveP: begin
        mul_a = {20'd0, a_mag_q};
        mul_b = {16'd0, motor_ratings_q[15:0]};
      end
      StDriveD: begin
        mul_a = {2'd0, p_q};
        mul_b = {16'd0, drive_split_q[{corner_q[0], 4'd0} +: 16]};
      end
      StDriveM: begin
        mul_a = d_q[corner_q[1]];
        mul_b = {3'd0, load_abs[28:0]};
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // calibrated load: product plus offset in 1/256 N
  logic [15:0] off16;
  logic [lct_pkg::LoadW-1:0] load_d;
  assign off16  = cell_offsets_q[{corner_q, 4'd0} +: 16];
  assign load_d = {2'd0, prod[27:0]} + {{6{off16[15]}}, off16, 8'd0};

  logic [lct_pkg::SumW-1:0] sum_d;
  assign sum_d = {{2{load_q[0][29]}}, load_q[0]} + {{2{load_q[1][29]}}, load_q[1]}
               + {{2{load_q[2][29]}}, load_q[2]} + {{2{load_q[3][29]}}, load_q[3]};
  logic sum_pos;
  assign sum_pos = !sum_q[31] && (sum_q != '0);

  // regen magnitude clamp
  logic [17:0] regen_m;
  logic [15:0] regen_lim;
  logic [17:0] regen_c;
  assign regen_m   = prod[43:26];
  assign regen_lim = regen_limits_q[{corner_q[0], 4'd0} +: 16];
  assign regen_c   = (regen_m > {2'd0, regen_lim}) ? {2'd0, regen_lim} : regen_m;

  // speed command
  logic [15:0] spd_mag;
  assign spd_mag = prod[27:12];

  // division step
  logic        div_ovf;
  logic [31:0] trial;
  logic        trial_ge;
  logic [31:0] trial_sub;
  assign div_ovf   = {3'd0, num_q[48:20]} >= sum_q;
  assign trial     = {rem_q, quo_q[lct_pkg::QuotW-1]};
  assign trial_ge  = trial >= sum_q;
  assign trial_sub = trial - sum_q;

  logic [lct_pkg::TorqueW-1:0] tq_sat;
  always_comb begin
    if (!neg_q) begin
      tq_sat = quo_q[lct_pkg::QuotW-1] ? lct_pkg::TorqueMaxPos : quo_q;
    end else if (quo_q > lct_pkg::TorqueMinNeg) begin
      tq_sat = lct_pkg::TorqueMinNeg;
    end else begin
      tq_sat = 20'd0 - quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      corner_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < lct_pkg::Corners; i++) begin
        runs_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            for (int i = 0; i < lct_pkg::Corners; i++) begin
              runs_q[i] <= runs_d[i];
              raw_q[i]  <= s_axis_tdata[24 + 12*i +: 12];
            end
            ok_q     <= ok_d;
            a_neg_q  <= a_diff[12];
            a_mag_q  <= a_diff[12] ? 12'(13'd0 - a_diff) : a_diff[11:0];
            corner_q <= '0;
            state_q  <= StLoad;
          end
        end
        StLoad: begin
          load_q[corner_q] <= load_d;
          corner_q <= corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            state_q <= StSum;
          end
        end
        StSum: begin
          sum_q   <= sum_d;
          state_q <= StDispatch;
        end
        StDispatch: begin
          for (int i = 0; i < lct_pkg::Corners; i++) begin
            tq_q[i] <= '0;
          end
          speed_q  <= '0;
          fault_q  <= !ok_q || (!speed_mode_q && !a_neg_q && !sum_pos);
          corner_q <= '0;
          if (!ok_q) begin
            state_q <= StDone;
          end else if (speed_mode_q) begin
            state_q <= StSpeed;
          end else if (a_neg_q) begin
            state_q <= StRegenA;
          end else if (!sum_pos) begin
            state_q <= StDone;
          end else begin
            state_q <= StDriveP;
          end
        end
        StSpeed: begin
          speed_q <= a_neg_q ? (17'd0 - {1'b0, spd_mag}) : {1'b0, spd_mag};
          state_q <= StDone;
        end
        StRegenA: begin
          t_q     <= prod[27:0];
          state_q <= StRegenB;
        end
        StRegenB: begin
          // corner_q[0] selects front or rear here
          tq_q[{corner_q[0], 1'b0}] <= 20'd0 - {2'd0, regen_c};
          tq_q[{corner_q[0], 1'b1}] <= 20'd0 - {2'd0, regen_c};
          corner_q <= corner_q + 2'd1;
          if (corner_q[0]) begin
            state_q <= StDone;
          end
        end
        StDriveP: begin
          p_q     <= {prod[27:0], 2'b00};
          state_q <= StDriveD;
        end
        StDriveD: begin
          d_q[corner_q[0]] <= prod[45:14];
          corner_q <= corner_q[0] ? 2'd0 : (corner_q + 2'd1);
          if (corner_q[0]) begin
            state_q  <= StDriveM;
          end
        end
        StDriveM: begin
          num_q   <= prod[60:12];
          neg_q   <= load_q[corner_q][29];
          state_q <= StDriveChk;
        end
        StDriveChk: begin
          if (div_ovf) begin
            // quotient beyond 20 bits saturates either way
            quo_q   <= {1'b1, {(lct_pkg::QuotW-1){1'b1}}};
            state_q <= StDriveWr;
          end else begin
            rem_q   <= {2'd0, num_q[48:20]};
            quo_q   <= num_q[19:0];
            step_q  <= '0;
            state_q <= StDriveDiv;
          end
        end
        StDriveDiv: begin
          rem_q  <= trial_ge ? trial_sub[30:0] : trial[30:0];
          quo_q  <= {quo_q[lct_pkg::QuotW-2:0], trial_ge};
          step_q <= step_q + 5'd1;
          if (step_q == 5'(lct_pkg::QuotW - 1)) begin
            state_q <= StDriveWr;
          end
        end
        StDriveWr: begin
          tq_q[corner_q] <= tq_sat;
          corner_q <= corner_q + 2'd1;
          state_q  <= (corner_q == 2'd3) ? StDone : StDriveM;
        end
        StDone: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {5'd0, fault_q, speed_q, tq_q[3], tq_q[2], tq_q[1], tq_q[0],
                            speed_mode_q};
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// File: tb/tb_load_cell_torque_vectoring.sv
// self-checking testbench for the load cell torque vectoring controller
module tb_load_cell_torque_vectoring;
  timeunit 1ns;
  timeprecision 1ps;

  import lct_pkg::*;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 120;

  typedef struct packed {
    logic [Corners-1:0]           ok;
    logic [Corners-1:0][RawW-1:0] raw;
    logic [FracW-1:0]             brake;
    logic [FracW-1:0]             accel;
  } pedal_sample_t;

  typedef struct packed {
    logic                            fault;
    logic [SpeedW-1:0]               speed;
    logic [Corners-1:0][TorqueW-1:0] torque;
    logic                            mode;
  } wheel_cmd_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // accel_fraction, brake_fraction, raw_fl, raw_fr, raw_rl, raw_rr,
  // valid_fl, valid_fr, valid_rl, valid_rr, zero fill
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // mode_out, torque_fl, torque_fr, torque_rl, torque_rr, wheel_speed, fault, zero fill
  logic [OutDataW-1:0] m_axis_tdata;

  load_cell_torque_vectoring u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // mirror of the control registers and the per-corner invalid run counts
  logic              mode_r;
  logic [7:0]        err_limit_r;
  logic [63:0]       scales_r;
  logic [63:0]       offsets_r;
  logic [31:0]       drive_split_r;
  logic [31:0]       regen_split_r;
  logic [31:0]       regen_lim_r;
  logic [47:0]       ratings_r;
  logic [CountW-1:0] invalid_run [Corners];

  wheel_cmd_t  pending_cmds [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on    = 1'b1;
  int unsigned stall_left   = 0;

  function automatic wheel_cmd_t predict_command(input pedal_sample_t smp);
    longint     load [Corners];
    longint     sum, a, p, d, q, m, lim, spd;
    longint     max_tq, max_regen, max_rpm;
    logic [15:0] split;
    bit         healthy;
    wheel_cmd_t cmd;
    cmd     = '0;
    healthy = 1'b1;
    sum     = 0;
    for (int i = 0; i < Corners; i++) begin
      load[i] = longint'(smp.raw[i]) * longint'(scales_r[16*i +: 16])
                + longint'($signed(offsets_r[16*i +: 16])) * 256;
      sum += load[i];
      if (smp.ok[i]) begin
        invalid_run[i] = '0;
      end else if (invalid_run[i] != CountSat) begin
        invalid_run[i] = invalid_run[i] + 1'b1;
      end
      if (invalid_run[i] >= err_limit_r) healthy = 1'b0;
    end
    a         = longint'(smp.accel) - longint'(smp.brake);
    max_tq    = longint'(ratings_r[15:0]);
    max_regen = longint'(ratings_r[31:16]);
    max_rpm   = longint'(ratings_r[47:32]);
    if (!healthy) begin
      cmd.fault = 1'b1;
    end else if (!mode_r) begin
      if (a >= 0) begin
        if (sum <= 0) begin
          cmd.fault = 1'b1;
        end else begin
          p = a * max_tq * 4;
          for (int i = 0; i < Corners; i++) begin
            split = (i < 2) ? drive_split_r[15:0] : drive_split_r[31:16];
            d = (p * longint'(split)) >>> 14;
            q = (d * load[i]) / (sum * 4096);
            if (q > 524287) q = 524287;
            else if (q < -524288) q = -524288;
            cmd.torque[i] = q[TorqueW-1:0];
          end
        end
      end else begin
        for (int i = 0; i < Corners; i++) begin
          split = (i < 2) ? regen_split_r[15:0] : regen_split_r[31:16];
          lim   = (i < 2) ? longint'(regen_lim_r[15:0]) : longint'(regen_lim_r[31:16]);
          m = (max_regen * (-a) * longint'(split)) >>> 26;
          if (m > lim) m = lim;
          m = -m;
          cmd.torque[i] = m[TorqueW-1:0];
        end
      end
    end else begin
      spd       = (a * max_rpm) / 4096;
      cmd.speed = spd[SpeedW-1:0];
    end
    cmd.mode = mode_r;
    return cmd;
  endfunction

  function automatic pedal_sample_t make_sample(input int accel, input int brake,
                                                input int r0, input int r1,
                                                input int r2, input int r3,
                                                input logic [3:0] ok);
    pedal_sample_t smp;
    smp.accel  = accel[FracW-1:0];
    smp.brake  = brake[FracW-1:0];
    smp.raw[0] = r0[RawW-1:0];
    smp.raw[1] = r1[RawW-1:0];
    smp.raw[2] = r2[RawW-1:0];
    smp.raw[3] = r3[RawW-1:0];
    smp.ok     = ok;
    return smp;
  endfunction

  function automatic pedal_sample_t random_sample(input logic [3:0] ok);
    pedal_sample_t smp;
    smp.accel = FracW'($urandom);
    smp.brake = FracW'($urandom);
    case ($urandom_range(0, 7))
      0: smp.brake = '0;
      1: smp.accel = '0;
      2: smp.brake = smp.accel;
      3: begin
        smp.accel = '1;
        smp.brake = '0;
      end
      4: begin
        smp.accel = '0;
        smp.brake = '1;
      end
      default: ;
    endcase
    for (int i = 0; i < Corners; i++) begin
      case ($urandom_range(0, 9))
        0:       smp.raw[i] = '0;
        1:       smp.raw[i] = '1;
        default: smp.raw[i] = RawW'($urandom);
      endcase
    end
    smp.ok = ok;
    return smp;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // registers only change once the block has gone quiet
  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegSpeedMode:    mode_r        = val[0];
      RegErrorLimit:   err_limit_r   = val[7:0];
      RegCellScales:   scales_r      = val;
      RegCellOffsets:  offsets_r     = val;
      RegDriveSplit:   drive_split_r = val[31:0];
      RegRegenSplit:   regen_split_r = val[31:0];
      RegRegenLimits:  regen_lim_r   = val[31:0];
      RegMotorRatings: ratings_r     = val[47:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input pedal_sample_t smp);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_cmds.push_back(predict_command(smp));
  endtask

  task automatic test_reset_defaults();
    // zero ratings give zero torque; an all-zero load sum faults the drive path
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 4'hF));
    send_sample(make_sample(4095, 0, 4095, 4095, 4095, 4095, 4'hF));
  endtask

  task automatic test_drive_split();
    set_reg(RegMotorRatings, 64'h0000_FFFF_FFFF_FFFF);
    set_reg(RegDriveSplit, 64'hFFFF_FFFF);
    set_reg(RegCellScales, 64'hFFFF_FFFF_FFFF_FFFF);
    set_reg(RegCellOffsets, 64'h0);
    send_sample(make_sample(4095, 0, 4095, 4095, 4095, 4095, 4'hF));
    send_sample(make_sample(4095, 0, 4095, 0, 0, 0, 4'hF));
    send_sample(make_sample(1, 0, 1, 2, 3, 4, 4'hF));
    send_sample(make_sample(2048, 2048, 100, 200, 300, 400, 4'hF));
    // tiny positive sum with one negative corner drives both saturation bounds
    set_reg(RegCellScales, CellScalesRst);
    set_reg(RegCellOffsets, 64'h0000_0000_0000_FFFF);
    send_sample(make_sample(4095, 0, 0, 2, 0, 0, 4'hF));
    set_reg(RegCellOffsets, 64'h8000_8000_8000_8000);
    send_sample(make_sample(100, 0, 4095, 4095, 4095, 4095, 4'hF));
  endtask

  task automatic test_regen();
    // negative load sum is left in place: regen must not fault on it
    set_reg(RegRegenSplit, 64'hFFFF_FFFF);
    set_reg(RegRegenLimits, 64'h1234_FFFF);
    send_sample(make_sample(0, 4095, 10, 10, 10, 10, 4'hF));
    send_sample(make_sample(0, 1, 10, 10, 10, 10, 4'hF));
    send_sample(make_sample(4094, 4095, 10, 10, 10, 10, 4'hF));
    set_reg(RegRegenLimits, 64'h0);
    send_sample(make_sample(0, 4095, 10, 10, 10, 10, 4'hF));
  endtask

  task automatic test_speed_mode();
    set_reg(RegSpeedMode, 64'h1);
    send_sample(make_sample(4095, 0, 0, 0, 0, 0, 4'hF));
    send_sample(make_sample(0, 4095, 0, 0, 0, 0, 4'hF));
    send_sample(make_sample(0, 1, 0, 0, 0, 0, 4'hF));
    send_sample(make_sample(1234, 5, 7, 7, 7, 7, 4'b1101));
  endtask

  task automatic test_fault_limits();
    set_reg(RegErrorLimit, 64'd1);
    send_sample(make_sample(4095, 0, 50, 50, 50, 50, 4'b1110));
    set_reg(RegSpeedMode, 64'h0);
    set_reg(RegCellOffsets, 64'h0);
    send_sample(make_sample(4095, 0, 50, 50, 50, 50, 4'hF));
    set_reg(RegErrorLimit, 64'd0);
    send_sample(make_sample(4095, 0, 50, 50, 50, 50, 4'hF));
    send_sample(make_sample(4095, 0, 50, 50, 50, 50, 4'b1001));
    set_reg(RegErrorLimit, 64'd2);
    send_sample(make_sample(4095, 0, 50, 60, 70, 80, 4'b0111));
    send_sample(make_sample(4095, 0, 50, 60, 70, 80, 4'b0111));
    send_sample(make_sample(4095, 0, 50, 60, 70, 80, 4'hF));
  endtask

  task automatic test_count_saturation();
    // a wrapping count would drop below the limit after 256 invalid samples
    set_reg(RegErrorLimit, 64'd255);
    for (int n = 0; n < 300; n++) send_sample(random_sample(4'b1110));
    for (int n = 0; n < 3; n++) send_sample(random_sample(4'hF));
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [15:0] f [4];
    int          burst_corner, burst_left;
    logic [3:0]  ok;
    for (int ph = 0; ph < phases; ph++) begin
      burst_left = 0;
      if (ph == 0) begin
        set_reg(RegSpeedMode, 64'h1);
        set_reg(RegErrorLimit, 64'hFF);
        set_reg(RegCellScales, '1);
        set_reg(RegCellOffsets, '1);
        set_reg(RegDriveSplit, '1);
        set_reg(RegRegenSplit, '1);
        set_reg(RegRegenLimits, '1);
        set_reg(RegMotorRatings, '1);
      end else if (ph == 1) begin
        set_reg(RegSpeedMode, 64'h0);
        set_reg(RegErrorLimit, 64'hFF);
        set_reg(RegCellScales, '0);
        set_reg(RegCellOffsets, '0);
        set_reg(RegDriveSplit, '0);
        set_reg(RegRegenSplit, '0);
        set_reg(RegRegenLimits, '0);
        set_reg(RegMotorRatings, '0);
      end else begin
        set_reg(RegSpeedMode, 64'($urandom_range(0, 2) == 0));
        case ($urandom_range(0, 9))
          0:       set_reg(RegErrorLimit, 64'd1);
          1:       set_reg(RegErrorLimit, 64'd255);
          2:       set_reg(RegErrorLimit, 64'd0);
          default: set_reg(RegErrorLimit, 64'($urandom_range(2, 20)));
        endcase
        for (int i = 0; i < 4; i++) begin
          f[i] = ($urandom_range(0, 2) == 0) ? pick16() : 16'($urandom_range(16'h80, 16'h200));
        end
        set_reg(RegCellScales, {f[3], f[2], f[1], f[0]});
        for (int i = 0; i < 4; i++) begin
          f[i] = ($urandom_range(0, 1) == 0) ? pick16() : 16'(int'($urandom_range(0, 200)) - 100);
        end
        set_reg(RegCellOffsets, {f[3], f[2], f[1], f[0]});
        set_reg(RegDriveSplit, 64'({pick16(), pick16()}));
        set_reg(RegRegenSplit, 64'({pick16(), pick16()}));
        set_reg(RegRegenLimits, 64'({pick16(), pick16()}));
        set_reg(RegMotorRatings, 64'({pick16(), pick16(), pick16()}));
      end
      // the closing phase runs with no idling on either side
      idling_on = (ph == phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < per_phase; n++) begin
        ok = '1;
        for (int i = 0; i < Corners; i++) begin
          if ($urandom_range(0, 19) == 0) ok[i] = 1'b0;
        end
        if (burst_left == 0 && $urandom_range(0, 39) == 0) begin
          burst_corner = $urandom_range(0, Corners - 1);
          burst_left   = $urandom_range(1, 12);
        end
        if (burst_left != 0) begin
          ok[burst_corner] = 1'b0;
          burst_left--;
        end
        send_sample(random_sample(ok));
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [TorqueW-1:0] want,
                               input logic [TorqueW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    wheel_cmd_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(wheel_cmd_t)-1:0];
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        compare_field("mode_out", TorqueW'(want.mode), TorqueW'(got.mode));
        compare_field("torque_fl", want.torque[0], got.torque[0]);
        compare_field("torque_fr", want.torque[1], got.torque[1]);
        compare_field("torque_rl", want.torque[2], got.torque[2]);
        compare_field("torque_rr", want.torque[3], got.torque[3]);
        compare_field("wheel_speed", TorqueW'(want.speed), TorqueW'(got.speed));
        compare_field("fault", TorqueW'(want.fault), TorqueW'(got.fault));
      end
    end
  end

  // receiver stalls in random bursts while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      stall_left    <= $urandom_range(1, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("load_cell_torque_vectoring regression: fail");
      $finish;
    end
  end

  initial begin
    mode_r        = 1'b0;
    err_limit_r   = ErrorLimitRst;
    scales_r      = CellScalesRst;
    offsets_r     = '0;
    drive_split_r = SplitRst;
    regen_split_r = SplitRst;
    regen_lim_r   = '0;
    ratings_r     = '0;
    for (int i = 0; i < Corners; i++) invalid_run[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_drive_split();
    test_regen();
    test_speed_mode();
    test_fault_limits();
    test_count_saturation();
    test_random(9, 170);
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("load_cell_torque_vectoring regression: pass");
    end else begin
      $display("load_cell_torque_vectoring regression: fail");
    end
    $finish;
  end

endmodule
